### rtl/mie_pkg.sv
// Package for the modular inverse block: sequencer state encoding.
// No dependencies; used by modular_inverse_ext_euclid.
package mie_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FIX,
    ST_RES
  } state_e;

endpackage

### rtl/mie_div.sv
// Shared radix-2 restoring divider for the Euclid rounds. It yields the remainder
// and, alongside, quotient * coefficient (mod 2^CW) by shift-and-add. No package use.
module mie_div #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [VALUE_BITS-1:0]   dividend_i,
  input  logic [VALUE_BITS-1:0]   divisor_i,   // held stable while busy
  input  logic [VALUE_BITS+1:0]   coef_i,      // held stable while busy
  output logic                    done_o,
  output logic [VALUE_BITS-1:0]   rem_o,
  output logic [VALUE_BITS+1:0]   prod_o
);

  localparam int unsigned N     = VALUE_BITS;
  localparam int unsigned CW    = VALUE_BITS + 2;
  localparam int unsigned CNT_W = $clog2(VALUE_BITS);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [N-1:0]     rem_q, dvd_q;
  logic [CW-1:0]    prod_q;

  logic [N:0]       trial, dvsr_ext, diff;
  logic             q_bit;

  assign trial    = {rem_q, dvd_q[N-1]};
  assign dvsr_ext = {1'b0, divisor_i};
  assign diff     = trial - dvsr_ext;
  assign q_bit    = (trial >= dvsr_ext);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(N - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      rem_q  <= '0;
      prod_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[N-2:0], 1'b0};
      rem_q  <= q_bit ? diff[N-1:0] : trial[N-1:0];
      prod_q <= {prod_q[CW-2:0], 1'b0} + (q_bit ? coef_i : '0);
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
  assign prod_o = prod_q;

endmodule

### rtl/modular_inverse_ext_euclid.sv
// Top level of the modular inverse block (extended Euclid, iterative).
// Depends on mie_pkg (state encoding) and mie_div (shared divider).
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one word {value_i, modulus_i}.
//   Output channel out_valid_o/out_ready_i carries {inverse_o, not_invertible_o}:
//   the inverse of value modulo modulus in 0..modulus-1, or 0 with the flag set
//   when value and modulus share a factor above one (value 0 and modulus 0 are
//   flagged too). A modulus of 1 gives 1, unflagged.
//   The block works on one word at a time; in_ready_o is high only while idle.
//   Each Euclid round runs one division through the shared divider, one
//   quotient bit per cycle. A flagged word or a modulus of one skips the fold
//   step; at 31 bits the worst case is about 45 rounds. in_ready_o rises in the
//   same cycle as out_valid_o, so the next word can be accepted from then on.
//   The finished word sits in an output register; while the receiver stalls a
//   new word can be accepted and worked on, and the sequencer only waits if its
//   next result is ready before the previous one was taken.
//   Reset (rst_ni, async, active low) returns the sequencer to idle and drops
//   out_valid_o; no other clearing is needed.
module modular_inverse_ext_euclid #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [VALUE_BITS-1:0] modulus_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_BITS-1:0] inverse_o,
  output logic                  not_invertible_o
);

  localparam int unsigned N  = VALUE_BITS;
  // Coefficients stay within +/- modulus, so two extra bits hold them exactly.
  localparam int unsigned CW = VALUE_BITS + 2;

  mie_pkg::state_e state_q, state_d;

  // Euclid working registers
  logic [N-1:0]  num_q, den_q, mod0_q;
  logic [CW-1:0] cp_q, cc_q;          // coefficients of num and den
  logic [N-1:0]  res_q;
  logic          bad_q;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic [N-1:0]  inverse_q;
  logic          flag_q;

  // Divider hookup
  logic          div_start, div_done;
  logic [N-1:0]  div_rem;
  logic [CW-1:0] div_prod;

  // Round checks
  logic chk_mod_one, chk_zero, chk_unit, chk_nodiv;
  logic out_load;
  logic [CW-1:0] fix_sum;

  assign chk_mod_one = (mod0_q == N'(1));
  assign chk_zero    = (mod0_q == '0) || (num_q == '0);
  assign chk_unit    = (num_q == N'(1));
  assign chk_nodiv   = (den_q == '0);

  // Negative coefficient folds back by one modulus.
  assign fix_sum = cp_q + {2'b00, mod0_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mie_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mie_pkg::ST_CHECK;
      end
      mie_pkg::ST_CHECK: begin
        if (chk_mod_one || chk_zero) state_d = mie_pkg::ST_RES;
        else if (chk_unit)           state_d = mie_pkg::ST_FIX;
        else if (chk_nodiv)          state_d = mie_pkg::ST_RES;
        else                         state_d = mie_pkg::ST_DIV;
      end
      mie_pkg::ST_DIV: begin
        if (div_done) state_d = mie_pkg::ST_CHECK;
      end
      mie_pkg::ST_FIX: begin
        state_d = mie_pkg::ST_RES;
      end
      mie_pkg::ST_RES: begin
        if (!out_valid_q || out_ready_i) state_d = mie_pkg::ST_IDLE;
      end
      default: state_d = mie_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o = (state_q == mie_pkg::ST_IDLE);
    div_start  = (state_q == mie_pkg::ST_CHECK) && !chk_mod_one && !chk_zero &&
                 !chk_unit && !chk_nodiv;
    out_load   = (state_q == mie_pkg::ST_RES) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mie_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      mie_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          num_q  <= value_i;
          den_q  <= modulus_i;
          mod0_q <= modulus_i;
          cp_q   <= CW'(1);
          cc_q   <= '0;
        end
      end
      mie_pkg::ST_CHECK: begin
        if (chk_mod_one) begin
          res_q <= N'(1);
          bad_q <= 1'b0;
        end else begin
          // zero operand or a common factor: flagged
          res_q <= '0;
          bad_q <= 1'b1;
        end
      end
      mie_pkg::ST_DIV: begin
        if (div_done) begin
          num_q <= den_q;
          den_q <= div_rem;
          cc_q  <= cp_q - div_prod;
          cp_q  <= cc_q;
        end
      end
      mie_pkg::ST_FIX: begin
        res_q <= cp_q[CW-1] ? fix_sum[N-1:0] : cp_q[N-1:0];
        bad_q <= 1'b0;
      end
      default: ;
    endcase
    if (out_load) begin
      inverse_q <= res_q;
      flag_q    <= bad_q;
    end
  end

  mie_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .coef_i     (cc_q),
    .done_o     (div_done),
    .rem_o      (div_rem),
    .prod_o     (div_prod)
  );

  assign out_valid_o      = out_valid_q;
  assign inverse_o        = inverse_q;
  assign not_invertible_o = flag_q;

  // Checks
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && not_invertible_o |-> inverse_o == '0)
    else $error("flagged word carries a nonzero inverse");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == mie_pkg::ST_DIV)
    else $error("divider finished outside a division round");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mie_pkg::ST_DIV |-> den_q != '0)
    else $error("division round started with a zero divisor");

  a_start_then_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == mie_pkg::ST_DIV && !div_done)
    else $error("divider start not followed by a division round");

endmodule
